/* design/xoroshiro_bounded_random_defines.svh */
// Assertion macros for the bounded xoroshiro128+ generator.
// No dependencies; the asserting files include this header by name.
`ifndef XOROSHIRO_BOUNDED_RANDOM_DEFINES_SVH
`define XOROSHIRO_BOUNDED_RANDOM_DEFINES_SVH
`ifndef SYNTHESIS
`define XBR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define XBR_NEVER(label, cond, msg) \
	`XBR_ASSERT(label, !(cond), msg)
`else
`define XBR_ASSERT(label, prop, msg)
`define XBR_NEVER(label, cond, msg)
`endif
`endif

/* design/xbr_pkg.sv */
// Shared types and constants of the bounded xoroshiro128+ generator.
// No dependencies.
`default_nettype none
package xbr_pkg;

	localparam int WORD_W      = 64;
	localparam int CFG_INDEX_W = 8;
	localparam int COUNT_W     = $clog2(WORD_W);

	localparam logic [CFG_INDEX_W-1:0] REG_SEED_FIRST  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SEED_SECOND = CFG_INDEX_W'(1);

	localparam logic [WORD_W-1:0] SEED_FIRST_RST  = WORD_W'(1);
	localparam logic [WORD_W-1:0] SEED_SECOND_RST = WORD_W'(0);

	localparam int ROT_A   = 24;
	localparam int SHIFT_B = 16;
	localparam int ROT_C   = 37;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic start;
		logic ack;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic word_t rot_left(input word_t v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

endpackage
`default_nettype wire

/* design/xbr_gen.sv */
// Seed registers and xoroshiro128+ state words; steps once per request.
// Depends on xbr_pkg.
`default_nettype none
module xbr_gen (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [xbr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [xbr_pkg::WORD_W-1:0]      cfg_data,
	input  wire                            step,
	output logic [xbr_pkg::WORD_W-1:0]     raw
);
	import xbr_pkg::*;

	word_t seed_first_q, seed_second_q;
	word_t gen_first_q, gen_second_q;
	word_t mix;

	assign raw = gen_first_q + gen_second_q;
	assign mix = gen_first_q ^ gen_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_first_q  <= SEED_FIRST_RST;
			seed_second_q <= SEED_SECOND_RST;
			gen_first_q   <= SEED_FIRST_RST;
			gen_second_q  <= SEED_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEED_FIRST: begin
					seed_first_q <= cfg_data;
					gen_first_q  <= cfg_data;
					gen_second_q <= seed_second_q;
				end
				REG_SEED_SECOND: begin
					seed_second_q <= cfg_data;
					gen_first_q   <= seed_first_q;
					gen_second_q  <= cfg_data;
				end
				default: ;
			endcase
		end else if (step) begin
			gen_first_q  <= rot_left(gen_first_q, ROT_A) ^ mix ^ (mix << SHIFT_B);
			gen_second_q <= rot_left(mix, ROT_C);
		end
	end

endmodule
`default_nettype wire

/* design/xbr_div.sv */
// Radix-2 restoring remainder unit: one dividend bit shifts in per cycle.
// Depends on xbr_pkg.
`default_nettype none
module xbr_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire xbr_pkg::div_ctrl_t    ctrl,
	input  wire [xbr_pkg::WORD_W-1:0]  dividend,
	input  wire [xbr_pkg::WORD_W-1:0]  divisor,
	output xbr_pkg::div_status_t       status,
	output logic [xbr_pkg::WORD_W-1:0] remainder
);
	import xbr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [COUNT_W-1:0] count_q;
	word_t              dvd_q, dsr_q, rem_q;
	logic [WORD_W:0]    trial, diff;

	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	assign status.busy = (state_q == ST_RUN);
	assign status.done = (state_q == ST_DONE);
	assign remainder   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (ctrl.start) begin
					state_q <= ST_RUN;
					count_q <= '0;
				end
				ST_RUN: begin
					count_q <= count_q + 1'b1;
					if (count_q == COUNT_W'(WORD_W - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: if (ctrl.ack) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ctrl.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (state_q == ST_RUN) begin
			dvd_q <= dvd_q << 1;
			rem_q <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
		end
	end

endmodule
`default_nettype wire

/* design/xoroshiro_bounded_random.sv */
// Top level of the bounded xoroshiro128+ generator.
// Depends on xbr_pkg, xbr_gen, xbr_div and xoroshiro_bounded_random_defines.svh.
//
// Each request carries a low and a high bound and steps the generator once.
// The result is (s0 + s1) mod (high - low + 1) plus low, or 0 when high is not
// above low; a range that wraps to zero acts as divisor 1. A request first
// loads the remainder unit, which then shifts in the dividend bits one at a
// time; the sum is then formed in the output register, and the next request
// is taken in the cycle after that. A new request is taken while an earlier
// result still waits downstream; a finished remainder then waits until the
// output register frees, which keeps the unit from taking the next request.
// Writing either seed register reloads both generator words; configuration
// writes complete in the cycle they appear.
`default_nettype none
`include "xoroshiro_bounded_random_defines.svh"
module xoroshiro_bounded_random (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire [2*xbr_pkg::WORD_W-1:0]    s_axis_tdata,  // bound_low, bound_high
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [xbr_pkg::WORD_W-1:0]     m_axis_tdata,  // random_value
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [xbr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [xbr_pkg::WORD_W-1:0]      cfg_data
);
	import xbr_pkg::*;

	word_t       bound_low, bound_high, raw, span, divisor, remainder;
	word_t       lo_q, m_data_q;
	logic        ok_q, m_valid_q, accept, unload;
	div_ctrl_t   div_ctrl;
	div_status_t div_st;

	assign bound_low  = s_axis_tdata[WORD_W-1:0];
	assign bound_high = s_axis_tdata[2*WORD_W-1:WORD_W];
	assign span       = bound_high - bound_low + WORD_W'(1);
	assign divisor    = (span == '0) ? WORD_W'(1) : span;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !div_st.busy && !div_st.done;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign unload        = div_st.done && (!m_valid_q || m_axis_tready);

	assign div_ctrl.start = accept;
	assign div_ctrl.ack   = unload;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	xbr_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.raw       (raw)
	);

	xbr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (raw),
		.divisor   (divisor),
		.status    (div_st),
		.remainder (remainder)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= bound_low;
			ok_q <= bound_high > bound_low;
		end
		if (unload)
			m_data_q <= ok_q ? remainder + lo_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (unload)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	`XBR_ASSERT(a_one_at_a_time, accept |=> !s_axis_tready, "request taken while busy")
	`XBR_ASSERT(a_done_after_run, $rose(div_st.done) |-> $past(div_st.busy), "done without run")
	`XBR_ASSERT(a_unload_shows, unload |=> m_axis_tvalid, "finished result not presented")
	`XBR_NEVER(a_no_lost_result, m_valid_q && !m_axis_tready && $past(unload) && unload,
		"result overwritten while stalled")

endmodule
`default_nettype wire
